// File: rtl/prad_pkg.sv
// shared types and op codes for the priority region address decoder
package prad_pkg;

	localparam int DEVICE_BITS = 4;
	localparam int ADDR_BITS   = 16;
	localparam int OP_BITS     = 3;

	localparam logic [OP_BITS-1:0] OP_MAP     = 3'd0;
	localparam logic [OP_BITS-1:0] OP_RD_BYTE = 3'd1;
	localparam logic [OP_BITS-1:0] OP_RD_WORD = 3'd2;
	localparam logic [OP_BITS-1:0] OP_WR_BYTE = 3'd3;
	localparam logic [OP_BITS-1:0] OP_WR_WORD = 3'd4;

	localparam logic STATUS_HIT      = 1'b0;
	localparam logic STATUS_UNMAPPED = 1'b1;

	typedef struct packed {
		logic [OP_BITS-1:0]     op;
		logic [ADDR_BITS-1:0]   addr;
		logic [ADDR_BITS-1:0]   end_addr;
		logic [DEVICE_BITS-1:0] device_id;
		logic                   remap;
		logic [ADDR_BITS-1:0]   value;
	} req_t;

	typedef struct packed {
		logic                   status;
		logic [DEVICE_BITS-1:0] target_device;
		logic [ADDR_BITS-1:0]   local_addr;
		logic [ADDR_BITS-1:0]   write_data;
		logic                   is_write;
		logic                   is_word;
	} rsp_t;

	// one table entry as held in a cell
	typedef struct packed {
		logic                   valid;
		logic [ADDR_BITS-1:0]   start;
		logic [ADDR_BITS-1:0]   last;
		logic [DEVICE_BITS-1:0] device;
		logic                   relative;
	} region_t;

	// lookup token walking down the chain
	typedef struct packed {
		logic                   active;
		logic                   hit;
		logic [DEVICE_BITS-1:0] device;
		logic [ADDR_BITS-1:0]   local_addr;
		logic [ADDR_BITS-1:0]   addr;
	} token_t;

endpackage

// File: rtl/prad_cell.sv
// one chain cell: holds a region, checks the passing lookup token against it
module prad_cell import prad_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  logic    advance,
	input  region_t region_in,
	output region_t region_out,
	input  token_t  tok_in,
	output token_t  tok_out
);

	region_t region_q;
	token_t  tok_q;
	token_t  tok_next;
	logic    match;

	// region shifts one slot back on a map transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (shift) begin
			region_q <= region_in;
		end
	end

	// first valid region containing the address claims the token
	always_comb begin
		match    = tok_in.active && !tok_in.hit && region_q.valid &&
			(tok_in.addr >= region_q.start) && (tok_in.addr <= region_q.last);
		tok_next = tok_in;
		if (match) begin
			tok_next.hit        = 1'b1;
			tok_next.device     = region_q.device;
			tok_next.local_addr = region_q.relative ? (tok_in.addr - region_q.start)
				: tok_in.addr;
		end
	end

	// token register, handed to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= tok_next;
		end
	end

	assign region_out = region_q;
	assign tok_out    = tok_q;

endmodule

// File: rtl/priority_region_address_decoder_unit.sv
// top level of the priority region address decoder, chain of region cells
//
// Usage:
//   in_valid/in_stall/in_data carry requests: map commands and byte or word
//   reads and writes. A map transfer places the region in the first cell and
//   moves every older region one cell back, the oldest dropping off the end.
//   It gives no result, and another request may follow at once. An access
//   runs as a token through the REGION_COUNT cells, one cell per cycle, the
//   nearest (newest) matching region claiming it.
//   out_valid/out_stall/out_data carry one result per access, registered
//   after the token leaves the last cell; the next access can be taken once
//   the result is registered, so a new access waits while the previous one
//   walks the cell chain. Codes 5 to 7 are dropped.
//   in_stall is high while an access is in the chain or waiting to enter the
//   output register. A stalled result holds in the output register and the
//   token waits in the last cell. Reset empties the chain and output and
//   marks every region invalid.
module priority_region_address_decoder_unit import prad_pkg::*; #(
	parameter int REGION_COUNT = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output rsp_t out_data
);

	region_t                  region_link [REGION_COUNT+1];
	token_t                   tok_link    [REGION_COUNT+1];
	logic [REGION_COUNT-1:0]  tok_active;

	logic                     busy_q;
	logic                     out_valid_q;
	rsp_t                     out_q;
	logic [ADDR_BITS-1:0]     wdata_q;
	logic                     is_write_q;
	logic                     is_word_q;

	logic                     accept;
	logic                     is_access;
	logic                     map_shift;
	logic                     last_active;
	logic                     load_out;
	logic                     advance;

	// request decode
	assign accept    = in_valid && !in_stall;
	assign is_access = (in_data.op == OP_RD_BYTE) || (in_data.op == OP_RD_WORD) ||
		(in_data.op == OP_WR_BYTE) || (in_data.op == OP_WR_WORD);
	assign map_shift = accept && (in_data.op == OP_MAP);
	assign in_stall  = busy_q;

	// chain head: new region and new token
	always_comb begin
		region_link[0]          = '0;
		region_link[0].valid    = 1'b1;
		region_link[0].start    = in_data.addr;
		region_link[0].last     = in_data.end_addr;
		region_link[0].device   = in_data.device_id;
		region_link[0].relative = in_data.remap;
		tok_link[0]             = '0;
		tok_link[0].active      = accept && is_access;
		tok_link[0].addr        = in_data.addr;
	end

	// result hand-over from the last cell
	assign last_active = tok_link[REGION_COUNT].active;
	assign load_out    = last_active && (!out_valid_q || !out_stall);
	assign advance     = !last_active || load_out;

	// row of region cells
	for (genvar i = 0; i < REGION_COUNT; i++) begin : g_cell
		prad_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (map_shift),
			.advance    (advance),
			.region_in  (region_link[i]),
			.region_out (region_link[i+1]),
			.tok_in     (tok_link[i]),
			.tok_out    (tok_link[i+1])
		);
		assign tok_active[i] = tok_link[i+1].active;
	end

	// access kind and write data kept while the token walks
	always_ff @(posedge clk) begin
		if (accept && is_access) begin
			is_write_q <= (in_data.op == OP_WR_BYTE) || (in_data.op == OP_WR_WORD);
			is_word_q  <= (in_data.op == OP_RD_WORD) || (in_data.op == OP_WR_WORD);
			if (in_data.op == OP_WR_WORD) begin
				wdata_q <= in_data.value;
			end else if (in_data.op == OP_WR_BYTE) begin
				wdata_q <= {{(ADDR_BITS-8){1'b0}}, in_data.value[7:0]};
			end else begin
				wdata_q <= '0;
			end
		end
	end

	// busy from access transfer until its result is registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && is_access) begin
			busy_q <= 1'b1;
		end else if (load_out) begin
			busy_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.status        <= tok_link[REGION_COUNT].hit ? STATUS_HIT : STATUS_UNMAPPED;
			out_q.target_device <= tok_link[REGION_COUNT].device;
			out_q.local_addr    <= tok_link[REGION_COUNT].local_addr;
			out_q.write_data    <= wdata_q;
			out_q.is_write      <= is_write_q;
			out_q.is_word       <= is_word_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_active) <= 1)
		else $error("more than one lookup token in the chain");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_active == '0))
		else $error("token in chain while not busy");

	a_access_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_access) |=> busy_q)
		else $error("access transfer did not mark busy");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid && !busy_q))
		else $error("result not presented after leaving the chain");

	a_no_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !map_shift)
		else $error("region table shifted during a lookup");

endmodule
